// ----- sv/smbs_pkg.sv -----
package smbs_pkg;

    typedef struct packed {
        logic       command;
        logic [7:0] tx_byte;
        logic       miso_level;
    } t_in_item;

    typedef struct packed {
        logic       sck_level;
        logic       mosi_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
    } t_out_item;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_POLARITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_PHASE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LSB_FIRST      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER_LOG2   = 2'd3;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    localparam logic [2:0] DIV_RESET = 3'd1;

endpackage

// ----- sv/smbs_queue.sv -----
module smbs_queue
    import smbs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_push_data,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_empty,
    output t_in_item o_head
);

    t_in_item   r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ----- sv/smbs_engine.sv -----
module smbs_engine
    import smbs_pkg::*;
#(
    parameter int WORD_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_item_valid,
    input  t_in_item              i_item,
    output logic                  o_item_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    localparam int ECW = $clog2(2 * WORD_BITS + 1);
    localparam int IW  = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

    logic                 r_cpol;
    logic                 r_cpha;
    logic                 r_lsb;
    logic [2:0]           r_div;

    logic [WORD_BITS-1:0] r_tx;
    logic [WORD_BITS-1:0] r_rx;
    logic [ECW-1:0]       r_ec;
    logic [6:0]           r_tick;
    logic                 r_sck;
    logic                 r_act;

    logic [WORD_BITS-1:0] n_tx;
    logic [WORD_BITS-1:0] n_rx;
    logic [ECW-1:0]       n_ec;
    logic [6:0]           n_tick;
    logic                 n_sck;
    logic                 n_act;

    logic                 r_out_valid;
    t_out_item            r_out;
    t_out_item            n_out;

    logic [2:0]           div_eff;
    logic [6:0]           half;
    logic [6:0]           tick_inc;
    logic [ECW-1:0]       ec_inc;
    logic [ECW-1:0]       nec_m1;
    logic [IW-1:0]        rx_idx;
    logic [IW-1:0]        tx_idx;
    logic [IW-1:0]        tx_pos;
    logic                 done;
    logic [7:0]           rx_out;

    assign o_item_pop  = i_item_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_tx     = r_tx;
        n_rx     = r_rx;
        n_ec     = r_ec;
        n_tick   = r_tick;
        n_sck    = r_sck;
        n_act    = r_act;
        done     = 1'b0;
        rx_out   = 8'd0;
        div_eff  = (r_div == 3'd0) ? 3'd1 : r_div;
        half     = 7'd1 << (div_eff - 3'd1);
        tick_inc = r_tick + 7'd1;
        ec_inc   = r_ec + ECW'(1);
        rx_idx   = r_ec[IW:1];
        if (!r_act) begin
            n_sck = r_cpol;
            if (i_item.command == CMD_START) begin
                n_tx   = WORD_BITS'(i_item.tx_byte);
                n_rx   = '0;
                n_ec   = '0;
                n_tick = 7'd0;
                n_act  = 1'b1;
            end
        end else begin
            n_tick = tick_inc;
            if (tick_inc >= half) begin
                n_tick = 7'd0;
                n_ec   = ec_inc;
                n_sck  = ~r_sck;
                if (ec_inc[0] == !r_cpha) begin
                    if (r_lsb) begin
                        n_rx[rx_idx] = r_rx[rx_idx] | i_item.miso_level;
                    end else begin
                        n_rx = {r_rx[WORD_BITS-2:0], i_item.miso_level};
                    end
                end
                if (ec_inc >= ECW'(2 * WORD_BITS)) begin
                    done   = 1'b1;
                    rx_out = 8'(n_rx);
                    n_act  = 1'b0;
                    n_ec   = '0;
                end
            end
        end
    end

    // data bit shown on mosi after this tick
    always_comb begin
        nec_m1 = n_ec - ECW'(1);
        if (r_cpha) begin
            tx_idx = (n_ec == '0) ? '0 : nec_m1[IW:1];
        end else begin
            tx_idx = n_ec[IW:1];
        end
        tx_pos = r_lsb ? tx_idx : (IW'(WORD_BITS - 1) - tx_idx);
        n_out.sck_level  = n_sck;
        n_out.mosi_level = n_act ? n_tx[tx_pos] : 1'b0;
        n_out.busy_res   = n_act;
        n_out.done_res   = done;
        n_out.rx_byte    = rx_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpol      <= 1'b0;
            r_cpha      <= 1'b0;
            r_lsb       <= 1'b0;
            r_div       <= DIV_RESET;
            r_tx        <= '0;
            r_rx        <= '0;
            r_ec        <= '0;
            r_tick      <= 7'd0;
            r_sck       <= 1'b0;
            r_act       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CLOCK_POLARITY: r_cpol <= i_cfg_data[0];
                    CFG_CLOCK_PHASE:    r_cpha <= i_cfg_data[0];
                    CFG_LSB_FIRST:      r_lsb  <= i_cfg_data[0];
                    CFG_DIVIDER_LOG2:   r_div  <= i_cfg_data;
                    default:            r_div  <= r_div;
                endcase
            end
            if (o_item_pop) begin
                r_tx   <= n_tx;
                r_rx   <= n_rx;
                r_ec   <= n_ec;
                r_tick <= n_tick;
                r_sck  <= n_sck;
                r_act  <= n_act;
            end
            if (o_item_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_pop) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- sv/spi_master_byte_shifter.sv -----
// one result per accepted tick, sustained rate one transfer per cycle,
// when the output does not stall; a result is registered when its tick
// is accepted, and shown in the cycle after; ticks pass the queue first
// input ready drops only when the queue is full under output stall
// synchronous active-low reset clears the queue, the engine state and
// sets the registers to mode 0, msb first, divider 2
module spi_master_byte_shifter
    import smbs_pkg::*;
#(
    parameter int WORD_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    logic     q_full;
    logic     q_empty;
    logic     q_pop;
    t_in_item q_head;

    assign o_in_ready = !q_full;

    smbs_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_in_valid && !q_full),
        .i_push_data (i_in_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_empty     (q_empty),
        .o_head      (q_head)
    );

    smbs_engine #(
        .WORD_BITS (WORD_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (!q_empty),
        .i_item       (q_head),
        .o_item_pop   (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

// ----- sv/smbs_checker.sv -----
module smbs_checker
    import smbs_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_out_item             o_out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res |->
            !o_out_data.busy_res && !o_out_data.mosi_level)
        else $error("done transfer still busy");

    a_rx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.done_res |-> o_out_data.rx_byte == 8'd0)
        else $error("rx byte shown without done");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("reset left output valid or input blocked");

endmodule

bind spi_master_byte_shifter smbs_checker u_smbs_checker (.*);

// ----- bench/tb_spi_master_byte_shifter.sv -----
module tb_spi_master_byte_shifter;
    import smbs_pkg::*;

    localparam int IDLE_PCT = 22;
    localparam int HOLD_CYCLES = 80;
    localparam logic [CFG_IDX_W-1:0] REG_IDX [4] = '{
        CFG_CLOCK_POLARITY, CFG_CLOCK_PHASE, CFG_LSB_FIRST, CFG_DIVIDER_LOG2
    };

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;

    spi_master_byte_shifter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow of the shifter state and registers
    logic       cfg_cpol = 1'b0;
    logic       cfg_cpha = 1'b0;
    logic       cfg_lsb  = 1'b0;
    logic [2:0] cfg_div  = DIV_RESET;
    logic [7:0] sh_tx    = '0;
    logic [7:0] sh_rx    = '0;
    logic [4:0] sh_edges = '0;
    logic [6:0] sh_ticks = '0;
    logic       sh_sck   = 1'b0;
    logic       sh_busy  = 1'b0;

    t_in_item  tick_q [$];
    t_out_item pins_q [$];
    t_out_item got_pins;
    int        bad       = 0;
    logic      in_xfer   = 1'b0;
    logic      src_calm  = 1'b0;
    logic      sink_calm = 1'b0;
    int        hold_req  = 0;
    int        hold_seen = 0;
    int        hold_left = 0;

    function automatic logic data_bit(input logic [7:0] w, input int idx);
        int pos;
        if (idx > 7) idx = 7;
        pos = cfg_lsb ? idx : 7 - idx;
        return w[3'(pos)];
    endfunction

    function automatic logic mosi_now();
        int idx;
        if (!sh_busy) return 1'b0;
        if (cfg_cpha) idx = (sh_edges == 0) ? 0 : (int'(sh_edges) - 1) / 2;
        else idx = int'(sh_edges) / 2;
        return data_bit(sh_tx, idx);
    endfunction

    function automatic t_out_item spi_tick(input t_in_item it);
        t_out_item r;
        int        half;
        int        idx;
        logic      leading;
        r = '0;
        if (!sh_busy) begin
            sh_sck = cfg_cpol;
            if (it.command == CMD_START) begin
                sh_tx    = it.tx_byte;
                sh_rx    = '0;
                sh_edges = '0;
                sh_ticks = '0;
                sh_busy  = 1'b1;
            end
        end else begin
            half = 1 << ((cfg_div == 0 ? 1 : int'(cfg_div)) - 1);
            sh_ticks = sh_ticks + 7'd1;
            if (int'(sh_ticks) >= half) begin
                sh_ticks = '0;
                sh_edges = sh_edges + 5'd1;
                sh_sck   = ~sh_sck;
                leading  = sh_edges[0];
                if (leading == !cfg_cpha) begin
                    idx = (int'(sh_edges) - 1) / 2;
                    if (cfg_lsb) sh_rx[3'(idx)] = sh_rx[3'(idx)] | it.miso_level;
                    else sh_rx = {sh_rx[6:0], it.miso_level};
                end
                if (sh_edges >= 5'd16) begin
                    r.done_res = 1'b1;
                    r.rx_byte  = sh_rx;
                    sh_busy    = 1'b0;
                    sh_edges   = '0;
                end
            end
        end
        r.sck_level  = sh_sck;
        r.mosi_level = mosi_now();
        r.busy_res   = sh_busy;
        return r;
    endfunction

    function automatic t_in_item mk(input logic c, input logic [7:0] b, input logic m);
        t_in_item t;
        t.command    = c;
        t.tx_byte    = b;
        t.miso_level = m;
        return t;
    endfunction

    function automatic t_in_item rand_tick();
        return mk(($urandom_range(0, 7) == 0) ? CMD_START : CMD_TICK,
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endfunction

    task automatic check_field(input string name, input logic [7:0] e, input logic [7:0] a);
        if (e !== a) begin
            bad++;
            $display("%0t: %s expected %h got %h", $time, name, e, a);
        end
    endtask

    // input prediction and output checking
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_xfer <= 1'b0;
        end else begin
            in_xfer <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) pins_q.push_back(spi_tick(i_in_data));
            if (o_out_valid && i_out_ready) begin
                if (pins_q.size() == 0) begin
                    bad++;
                    $display("%0t: unexpected result, expected none got %h", $time, o_out_data);
                end else begin
                    got_pins = pins_q.pop_front();
                    check_field("sck_level", 8'(got_pins.sck_level),
                                8'(o_out_data.sck_level));
                    check_field("mosi_level", 8'(got_pins.mosi_level),
                                8'(o_out_data.mosi_level));
                    check_field("busy_res", 8'(got_pins.busy_res),
                                8'(o_out_data.busy_res));
                    check_field("done_res", 8'(got_pins.done_res),
                                8'(o_out_data.done_res));
                    check_field("rx_byte", got_pins.rx_byte, o_out_data.rx_byte);
                end
            end
        end
    end

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_xfer) begin
            if (tick_q.size() > 0 && (src_calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                i_in_valid <= 1'b1;
                i_in_data  <= tick_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
                i_in_data  <= rand_tick();
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen   <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= sink_calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic load_regs(input logic [3:0] which, input logic [2:0] v0, input logic [2:0] v1,
                             input logic [2:0] v2, input logic [2:0] v3);
        logic [2:0] v [4];
        v[0] = v0;
        v[1] = v1;
        v[2] = v2;
        v[3] = v3;
        for (int i = 0; i < 4; i++) begin
            if (which[i]) begin
                @(negedge i_clk);
                i_cfg_we    <= 1'b1;
                i_cfg_index <= REG_IDX[i];
                i_cfg_data  <= v[i];
                @(posedge i_clk);
                case (REG_IDX[i])
                    CFG_CLOCK_POLARITY: cfg_cpol = v[i][0];
                    CFG_CLOCK_PHASE:    cfg_cpha = v[i][0];
                    CFG_LSB_FIRST:      cfg_lsb  = v[i][0];
                    CFG_DIVIDER_LOG2:   cfg_div  = v[i];
                    default: ;
                endcase
            end
        end
        if (which != 4'b0) begin
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
        end
        @(posedge i_clk);
    endtask

    // wait until every transfer is through, then let the pipeline settle
    task automatic drain();
        while (tick_q.size() != 0 || i_in_valid || pins_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int         n;
        logic [2:0] d;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_regs(4'hF, 3'd0, 3'd0, 3'd0, DIV_RESET);
        // start, start while busy, then plain ticks
        tick_q.push_back(mk(CMD_START, 8'hA5, 1'b1));
        tick_q.push_back(mk(CMD_START, 8'h5A, 1'b0));
        for (int k = 0; k < 6; k++) tick_q.push_back(mk(CMD_TICK, 8'hFF, k[0]));
        drain();
        // polarity and zero divider mid transfer
        load_regs(4'b1001, 3'b001, 3'd0, 3'd0, 3'd0);
        for (int k = 0; k < 5; k++) tick_q.push_back(mk(CMD_TICK, 8'h00, 1'b1));
        drain();
        // phase, order and divider mid transfer
        load_regs(4'b1110, 3'd0, 3'b111, 3'b101, 3'd2);
        for (int k = 0; k < 8; k++) tick_q.push_back(mk(CMD_TICK, 8'h00, ~k[1]));
        tick_q.push_back(mk(CMD_START, 8'hFF, 1'b0));
        tick_q.push_back(mk(CMD_START, 8'h00, 1'b1));

        for (int ph = 0; ph < 14; ph++) begin
            drain();
            case (ph)
                0: load_regs(4'hF, 3'd0, 3'd0, 3'd0, 3'd1);
                1: load_regs(4'hF, 3'd1, 3'd1, 3'd1, 3'd7);
                2: load_regs(4'hF, 3'd2, 3'd1, 3'd6, 3'd0);
                3: load_regs(4'hF, 3'd7, 3'd4, 3'd3, 3'd2);
                default: begin
                    d = 3'($urandom_range(0, 3));
                    if ($urandom_range(0, 5) == 0) d = 3'($urandom_range(4, 6));
                    load_regs(4'($urandom_range(1, 15)), 3'($urandom_range(0, 7)),
                              3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), d);
                end
            endcase
            src_calm  = (ph == 4) || (ph == 7);
            sink_calm = (ph == 4);
            n = (ph == 1) ? 300 : 70;
            tick_q.push_back(mk(CMD_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
            for (int k = 1; k < n; k++) tick_q.push_back(rand_tick());
            if (ph == 7) begin
                repeat (10) @(posedge i_clk);
                hold_req++;
            end
            if (ph == 1) begin
                // slowest divider cut short mid transfer
                drain();
                load_regs(4'b1000, 3'd0, 3'd0, 3'd0, 3'd1);
                for (int k = 0; k < 60; k++) tick_q.push_back(rand_tick());
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (bad == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- spi_master_byte_shifter.f -----
sv/smbs_pkg.sv
sv/smbs_queue.sv
sv/smbs_engine.sv
sv/spi_master_byte_shifter.sv
sv/smbs_checker.sv
bench/tb_spi_master_byte_shifter.sv
